### src/bpa_pkg.sv
// bpa_pkg: constants and item types of the buddy page allocator
// no dependencies

package bpa_pkg;

	localparam int PAGES     = 4096;
	localparam int MAX_ORDER = 8;
	localparam int PAGE_W    = 12;
	localparam int LINK_W    = 13;
	localparam int ORD_W     = 4;
	localparam int STAT_W    = 3;
	localparam int CNT_W     = 13;
	localparam int BLK       = 1 << MAX_ORDER;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGES);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_ORDER   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOBLOCK = 3'd2;
	localparam logic [STAT_W-1:0] ST_ALIGN   = 3'd3;
	localparam logic [STAT_W-1:0] ST_CORRUPT = 3'd4;

	typedef struct packed {
		logic              op;
		logic [ORD_W-1:0]  order;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PAGE_W-1:0] block_page;
		logic [CNT_W-1:0]  pages_avail;
	} rsp_t;

endpackage

### src/bpa_ram.sv
// bpa_ram: generic single write, single read memory with registered read
// no dependencies

module bpa_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/buddy_page_allocator.sv
// buddy_page_allocator: binary buddy page allocator, top level
// depends on bpa_pkg and bpa_ram
//
// One request is taken at a time and answered with exactly one item. A small
// sequencer walks the orders one level at a time through the link and pair-bit
// memories, each level a read followed by an evaluate or a write. Allocate
// scans the lists upward from the requested order, checks the pair bits below
// the found block, pops it, pushes the split halves and then delivers. Free
// checks the link, checks pair bits upward, merges while the buddy is free,
// pushes the result and then delivers. A rejected order or a misaligned free
// is answered without a memory walk. Each answer returns to idle before the
// next request is taken. After reset a clearing pass over all 4096 pages sets
// up the link and pair-bit memories; no item is taken before it ends.

module buddy_page_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpa_pkg::rsp_t rsp
);

	localparam int PW = bpa_pkg::PAGE_W;
	localparam int LW = bpa_pkg::LINK_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam int CW = bpa_pkg::CNT_W;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_A_FIND, S_A_CHK_RD, S_A_CHK_EV, S_A_POP_RD, S_A_POP_WR1, S_A_POP_WR2,
		S_PUSH1, S_PUSH2,
		S_F_LNK_RD, S_F_LNK_EV, S_F_CHK_RD, S_F_CHK_EV,
		S_F_MRG_RD, S_F_MRG_EV, S_F_MRG_CLR,
		S_FIN
	} state_t;

	state_t                    state_q;
	logic [PW-1:0]             clr_q;
	logic [PW-1:0]             p_q;
	logic [PW-1:0]             page_q;
	logic [OW-1:0]             k_q;
	logic [OW-1:0]             top_q;
	logic [OW-1:0]             ord_q;
	logic                      op_q;
	logic [bpa_pkg::STAT_W-1:0] st_q;
	logic [CW-1:0]             free_q;
	logic [LW-1:0]             head_q [bpa_pkg::MAX_ORDER+1];
	bpa_pkg::rsp_t             out_q;
	logic                      out_valid_q;

	logic [CW-1:0] slot_base;
	logic [PW-1:0] slot;
	logic [PW-1:0] kbit;
	logic [PW-1:0] buddy;
	logic [PW-1:0] tgt;
	logic [LW-1:0] h;
	logic          linked;
	logic          max_k;
	logic          k1_lt_max;

	logic          next_we, prev_we, pair_we;
	logic [PW-1:0] next_wa, prev_wa, pair_wa;
	logic [LW-1:0] next_wd, prev_wd;
	logic          pair_wd;
	logic [PW-1:0] next_ra, prev_ra;
	logic [LW-1:0] nx_rd, pr_rd;
	logic          pb_rd;

	logic [LW-1:0] clr_next, clr_prev;
	logic          clr_top;

	logic [CW-1:0] size;
	logic [CW-1:0] cnt_sub;
	logic [CW:0]   cnt_add;
	logic [CW-1:0] cnt_next;

	// shared shift unit: pair-bit slot and buddy of the current page and order
	assign slot_base = CW'(bpa_pkg::PAGES) - (CW'(bpa_pkg::PAGES) >> k_q);
	assign slot      = PW'(slot_base + CW'(p_q >> ({1'b0, k_q} + 5'd1)));
	assign kbit      = PW'(1) << k_q;
	assign buddy     = p_q ^ kbit;
	assign tgt       = (op_q == bpa_pkg::OP_ALLOC) ? buddy : p_q;
	assign h         = head_q[k_q];
	assign max_k     = (k_q == OW'(bpa_pkg::MAX_ORDER));
	assign k1_lt_max = (({1'b0, k_q} + 5'd1) < 5'(bpa_pkg::MAX_ORDER));

	always_comb begin
		linked = (pr_rd != bpa_pkg::NIL);
		for (int i = 0; i <= bpa_pkg::MAX_ORDER; i++) begin
			if (head_q[i] == {1'b0, p_q}) begin
				linked = 1'b1;
			end
		end
	end

	// reset image of the links: top blocks chained both ways
	assign clr_top  = (clr_q[bpa_pkg::MAX_ORDER-1:0] == '0);
	assign clr_next = (clr_top && (clr_q >= PW'(bpa_pkg::BLK)))
		? ({1'b0, clr_q} - LW'(bpa_pkg::BLK)) : bpa_pkg::NIL;
	assign clr_prev = (clr_top && (clr_q < PW'(bpa_pkg::PAGES - bpa_pkg::BLK)))
		? ({1'b0, clr_q} + LW'(bpa_pkg::BLK)) : bpa_pkg::NIL;

	assign next_ra = (state_q == S_A_POP_RD) ? p_q : buddy;
	assign prev_ra = (state_q == S_F_LNK_RD) ? p_q : buddy;

	always_comb begin
		next_we = 1'b0;
		next_wa = p_q;
		next_wd = bpa_pkg::NIL;
		prev_we = 1'b0;
		prev_wa = p_q;
		prev_wd = bpa_pkg::NIL;
		pair_we = 1'b0;
		pair_wa = slot;
		pair_wd = ~pb_rd;
		case (state_q)
			S_CLR: begin
				next_we = 1'b1;
				next_wa = clr_q;
				next_wd = clr_next;
				prev_we = 1'b1;
				prev_wa = clr_q;
				prev_wd = clr_prev;
				pair_we = 1'b1;
				pair_wa = clr_q;
				pair_wd = 1'b0;
			end
			S_A_POP_WR1: begin
				next_we = 1'b1;
				prev_we = (nx_rd < bpa_pkg::NIL);
				prev_wa = nx_rd[PW-1:0];
				pair_we = 1'b1;
			end
			S_A_POP_WR2: begin
				prev_we = 1'b1;
			end
			S_PUSH1: begin
				next_we = 1'b1;
				next_wa = tgt;
				next_wd = h;
				prev_we = 1'b1;
				prev_wa = tgt;
			end
			S_PUSH2: begin
				prev_we = (h < bpa_pkg::NIL);
				prev_wa = h[PW-1:0];
				prev_wd = {1'b0, tgt};
				pair_we = (op_q == bpa_pkg::OP_ALLOC);
			end
			S_F_MRG_EV: begin
				pair_we = 1'b1;
				if (pb_rd) begin
					next_we = (pr_rd < bpa_pkg::NIL);
					next_wa = pr_rd[PW-1:0];
					next_wd = nx_rd;
					prev_we = (nx_rd < bpa_pkg::NIL);
					prev_wa = nx_rd[PW-1:0];
					prev_wd = pr_rd;
				end
			end
			S_F_MRG_CLR: begin
				next_we = 1'b1;
				next_wa = buddy;
				prev_we = 1'b1;
				prev_wa = buddy;
			end
			default: begin
			end
		endcase
	end

	bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(nx_rd)
	);

	bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGES)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(prev_ra), .rdata(pr_rd)
	);

	bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::PAGES)) u_pair (
		.clk(clk), .we(pair_we), .waddr(pair_wa), .wdata(pair_wd),
		.raddr(slot), .rdata(pb_rd)
	);

	// free page count after the request
	assign size    = CW'(1) << ord_q;
	assign cnt_sub = (free_q >= size) ? (free_q - size) : '0;
	assign cnt_add = {1'b0, free_q} + {1'b0, size};
	always_comb begin
		if (st_q != bpa_pkg::ST_OK) begin
			cnt_next = free_q;
		end else if (op_q == bpa_pkg::OP_ALLOC) begin
			cnt_next = cnt_sub;
		end else if (cnt_add > (CW+1)'(bpa_pkg::PAGES)) begin
			cnt_next = CW'(bpa_pkg::PAGES);
		end else begin
			cnt_next = cnt_add[CW-1:0];
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			p_q         <= '0;
			page_q      <= '0;
			k_q         <= '0;
			top_q       <= '0;
			ord_q       <= '0;
			op_q        <= bpa_pkg::OP_ALLOC;
			st_q        <= bpa_pkg::ST_OK;
			free_q      <= CW'(bpa_pkg::PAGES);
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < bpa_pkg::MAX_ORDER; i++) begin
				head_q[i] <= bpa_pkg::NIL;
			end
			head_q[bpa_pkg::MAX_ORDER] <= LW'(bpa_pkg::PAGES - bpa_pkg::BLK);
		end else begin
			if (out_valid_q && !rsp_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(bpa_pkg::PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						ord_q  <= req.order;
						k_q    <= req.order;
						op_q   <= req.op;
						p_q    <= req.page_index;
						page_q <= req.page_index;
						if (req.order > OW'(bpa_pkg::MAX_ORDER)) begin
							st_q    <= bpa_pkg::ST_ORDER;
							state_q <= S_FIN;
						end else if (req.op == bpa_pkg::OP_ALLOC) begin
							st_q    <= bpa_pkg::ST_OK;
							state_q <= S_A_FIND;
						end else if ((req.page_index &
							((PW'(1) << req.order) - PW'(1))) != '0) begin
							st_q    <= bpa_pkg::ST_ALIGN;
							state_q <= S_FIN;
						end else begin
							st_q    <= bpa_pkg::ST_OK;
							state_q <= S_F_LNK_RD;
						end
					end
				end
				S_A_FIND: begin
					if (h < bpa_pkg::NIL) begin
						p_q   <= h[PW-1:0];
						top_q <= k_q;
						if (ord_q < k_q) begin
							k_q     <= ord_q;
							state_q <= S_A_CHK_RD;
						end else begin
							state_q <= S_A_POP_RD;
						end
					end else if (max_k) begin
						st_q    <= bpa_pkg::ST_NOBLOCK;
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + OW'(1);
					end
				end
				S_A_CHK_RD: begin
					state_q <= S_A_CHK_EV;
				end
				S_A_CHK_EV: begin
					if (pb_rd) begin
						st_q    <= bpa_pkg::ST_CORRUPT;
						state_q <= S_FIN;
					end else if (({1'b0, k_q} + 5'd1) < {1'b0, top_q}) begin
						k_q     <= k_q + OW'(1);
						state_q <= S_A_CHK_RD;
					end else begin
						k_q     <= top_q;
						state_q <= S_A_POP_RD;
					end
				end
				S_A_POP_RD: begin
					state_q <= S_A_POP_WR1;
				end
				S_A_POP_WR1: begin
					head_q[k_q] <= nx_rd;
					state_q     <= S_A_POP_WR2;
				end
				S_A_POP_WR2: begin
					if (k_q > ord_q) begin
						k_q     <= k_q - OW'(1);
						state_q <= S_PUSH1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_PUSH1: begin
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					head_q[k_q] <= {1'b0, tgt};
					if ((op_q == bpa_pkg::OP_ALLOC) && (k_q > ord_q)) begin
						k_q     <= k_q - OW'(1);
						state_q <= S_PUSH1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_F_LNK_RD: begin
					state_q <= S_F_LNK_EV;
				end
				S_F_LNK_EV: begin
					if (linked) begin
						st_q    <= bpa_pkg::ST_CORRUPT;
						state_q <= S_FIN;
					end else if (!max_k) begin
						state_q <= S_F_CHK_RD;
					end else begin
						state_q <= S_PUSH1;
					end
				end
				S_F_CHK_RD: begin
					state_q <= S_F_CHK_EV;
				end
				S_F_CHK_EV: begin
					if (!pb_rd) begin
						p_q     <= page_q;
						k_q     <= ord_q;
						state_q <= S_F_MRG_RD;
					end else if ((h != {1'b0, buddy}) && (pr_rd == bpa_pkg::NIL)) begin
						st_q    <= bpa_pkg::ST_CORRUPT;
						state_q <= S_FIN;
					end else if (k1_lt_max) begin
						p_q     <= p_q & ~kbit;
						k_q     <= k_q + OW'(1);
						state_q <= S_F_CHK_RD;
					end else begin
						p_q     <= page_q;
						k_q     <= ord_q;
						state_q <= S_F_MRG_RD;
					end
				end
				S_F_MRG_RD: begin
					state_q <= S_F_MRG_EV;
				end
				S_F_MRG_EV: begin
					if (!pb_rd) begin
						state_q <= S_PUSH1;
					end else begin
						if (h == {1'b0, buddy}) begin
							head_q[k_q] <= nx_rd;
						end
						state_q <= S_F_MRG_CLR;
					end
				end
				S_F_MRG_CLR: begin
					p_q <= p_q & ~kbit;
					k_q <= k_q + OW'(1);
					if (k1_lt_max) begin
						state_q <= S_F_MRG_RD;
					end else begin
						state_q <= S_PUSH1;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !rsp_stall) begin
						out_q.status      <= st_q;
						out_q.block_page  <= ((st_q == bpa_pkg::ST_OK) &&
							(op_q == bpa_pkg::OP_ALLOC)) ? p_q : '0;
						out_q.pages_avail <= cnt_next;
						out_valid_q       <= 1'b1;
						free_q            <= cnt_next;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
